// File: rtl/pgr_pkg.sv
// pgr_pkg: shared widths, item types, register indexes and the velocity
// update function for the pointer gesture recognizer
// no dependencies
package pgr_pkg;

  localparam int COORD_BITS = 16;
  localparam int VEL_BITS   = 24;
  localparam int GAIN_BITS  = 8;
  localparam int CFG_IDX_W  = 8;
  localparam int NUM_EVENTS = 9;

  localparam int DELTA_BITS = COORD_BITS + 1;
  localparam int SUM_W      = ((VEL_BITS > DELTA_BITS) ? VEL_BITS : DELTA_BITS) + 2;
  localparam int PROD_W     = VEL_BITS + GAIN_BITS + 1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TRACE_GAIN = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FADE_GAIN  = CFG_IDX_W'(1);

  localparam logic [GAIN_BITS-1:0] TRACE_GAIN_RST = GAIN_BITS'(192);
  localparam logic [GAIN_BITS-1:0] FADE_GAIN_RST  = GAIN_BITS'(230);

  // event bit positions
  localparam int EV_DECIDE    = 0;
  localparam int EV_CANCEL    = 1;
  localparam int EV_WHEEL_UP  = 2;
  localparam int EV_WHEEL_DN  = 3;
  localparam int EV_MOVE      = 4;
  localparam int EV_DRAG      = 5;
  localparam int EV_DROP      = 6;
  localparam int EV_FLICK     = 7;
  localparam int EV_EXT       = 8;

  typedef struct packed {
    logic                          pos_clipped;
    logic signed [COORD_BITS-1:0]  pos_y;
    logic signed [COORD_BITS-1:0]  pos_x;
    logic                          wheel_down;
    logic                          wheel_up;
    logic                          button_middle;
    logic                          button_secondary;
    logic                          button_primary;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0]  drag_start_y;
    logic signed [COORD_BITS-1:0]  drag_start_x;
    logic signed [VEL_BITS-1:0]    flick_vel_y;
    logic signed [VEL_BITS-1:0]    flick_vel_x;
    logic signed [DELTA_BITS-1:0]  delta_y;
    logic signed [DELTA_BITS-1:0]  delta_x;
    logic                          any_event;
    logic [NUM_EVENTS-1:0]         event_flags;
  } out_item_t;

  localparam int IN_TDATA_W  = (($bits(in_item_t) + 7) / 8) * 8;
  localparam int OUT_TDATA_W = (($bits(out_item_t) + 7) / 8) * 8;

  // v * gain / 256 truncated toward zero, plus an addend, saturated
  function automatic logic signed [VEL_BITS-1:0] vel_update(
    input logic signed [VEL_BITS-1:0]   v,
    input logic [GAIN_BITS-1:0]         gain,
    input logic signed [DELTA_BITS-1:0] add
  );
    logic signed [PROD_W-1:0]   prod;
    logic signed [PROD_W-1:0]   biased;
    logic signed [VEL_BITS:0]   quo;
    logic signed [SUM_W-1:0]    sum;
    logic [SUM_W-VEL_BITS:0]    top;
    prod = PROD_W'(v) * PROD_W'($signed({1'b0, gain}));
    if (prod[PROD_W-1]) begin
      biased = prod + PROD_W'(255);
    end else begin
      biased = prod;
    end
    quo = biased[PROD_W-1:GAIN_BITS];
    sum = SUM_W'(quo) + SUM_W'(add);
    top = sum[SUM_W-1:VEL_BITS-1];
    if ((&top) || !(|top)) begin
      vel_update = sum[VEL_BITS-1:0];
    end else if (sum[SUM_W-1]) begin
      vel_update = {1'b1, {(VEL_BITS-1){1'b0}}};
    end else begin
      vel_update = {1'b0, {(VEL_BITS-1){1'b1}}};
    end
  endfunction

endpackage

// File: rtl/pointer_gesture_recognizer.sv
// pointer_gesture_recognizer: top level, frame sample in, event result out
// depends on pgr_pkg
// path: an item accepted on in_ is held in the input register; its result is
//   then registered in the output register when out_ is free and offered on out_
// throughput: one item per cycle unless out_ back-pressures; the input register feeds
//   the event and velocity logic, whose result and state update are registered together
// reset: rst_n synchronous active low; clears all tracked state to zero,
//   trace_gain to 192 and fade_gain to 230, and empties both registers
module pointer_gesture_recognizer (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // button_primary, button_secondary, button_middle, wheel_up, wheel_down,
  // pos_x, pos_y, pos_clipped, zero pad
  input  logic [pgr_pkg::IN_TDATA_W-1:0]      in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // event_flags, any_event, delta_x, delta_y, flick_vel_x, flick_vel_y,
  // drag_start_x, drag_start_y, zero pad
  output logic [pgr_pkg::OUT_TDATA_W-1:0]     out_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pgr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pgr_pkg::GAIN_BITS-1:0]       cfg_data
);

  localparam int C = pgr_pkg::COORD_BITS;
  localparam int V = pgr_pkg::VEL_BITS;
  localparam int D = pgr_pkg::DELTA_BITS;

  logic                             in_vld_r, in_vld_nxt;
  logic                             out_vld_r, out_vld_nxt;
  pgr_pkg::in_item_t                in_r;
  pgr_pkg::out_item_t               out_r, out_nxt;
  logic [pgr_pkg::GAIN_BITS-1:0]    trace_gain_r, fade_gain_r;

  logic                             last_prim_r, last_sec_r, last_mid_r;
  logic                             last_drag_r, last_flick_r, click_en_r;
  logic                             click_en_nxt, drag_nxt, flick_nxt;
  logic signed [C-1:0]              last_x_r, last_y_r, start_x_r, start_y_r;
  logic signed [C-1:0]              start_x_nxt, start_y_nxt;
  logic signed [V-1:0]              vel_x_r, vel_y_r, vel_x_nxt, vel_y_nxt;

  logic                             in_accept, advance;
  logic signed [D-1:0]              dx, dy, add_x, add_y;
  logic signed [V-1:0]              upd_x, upd_y;
  logic [pgr_pkg::GAIN_BITS-1:0]    gain;
  logic                             ev_dec, ev_can, ev_ext, ev_move, ev_drag, ev_drop;
  logic                             flick_cancel;
  logic [pgr_pkg::NUM_EVENTS-1:0]   flags;

  assign cfg_ready  = 1'b1;
  assign advance    = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready  = !in_vld_r || advance;
  assign in_accept  = in_tvalid && in_tready;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = pgr_pkg::OUT_TDATA_W'(out_r);

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_accept) begin
      in_vld_nxt = 1'b1;
    end else if (advance) begin
      in_vld_nxt = 1'b0;
    end
    out_vld_nxt = out_vld_r;
    if (advance) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  // frame rules
  always_comb begin
    dx = {in_r.pos_x[C-1], in_r.pos_x} - {last_x_r[C-1], last_x_r};
    dy = {in_r.pos_y[C-1], in_r.pos_y} - {last_y_r[C-1], last_y_r};
    ev_dec  = !last_prim_r && in_r.button_primary && !in_r.pos_clipped;
    ev_can  = !last_sec_r && in_r.button_secondary && !in_r.pos_clipped;
    ev_ext  = !last_mid_r && in_r.button_middle && !in_r.pos_clipped;
    ev_move = (|dx) || (|dy);
    ev_drag = click_en_r && in_r.button_primary && last_prim_r && (ev_move || last_drag_r);
    ev_drop = !in_r.button_primary && last_prim_r && last_drag_r;

    if (!in_r.button_primary) begin
      click_en_nxt = 1'b0;
    end else if (ev_dec) begin
      click_en_nxt = 1'b1;
    end else begin
      click_en_nxt = click_en_r;
    end
    start_x_nxt = ev_dec ? in_r.pos_x : start_x_r;
    start_y_nxt = ev_dec ? in_r.pos_y : start_y_r;

    // shared scaler: fade while coasting, trace while dragging
    gain  = last_flick_r ? fade_gain_r : trace_gain_r;
    add_x = last_flick_r ? '0 : dx;
    add_y = last_flick_r ? '0 : dy;
    upd_x = pgr_pkg::vel_update(vel_x_r, gain, add_x);
    upd_y = pgr_pkg::vel_update(vel_y_r, gain, add_y);

    if (last_flick_r) begin
      vel_x_nxt = upd_x;
      vel_y_nxt = upd_y;
      flick_nxt = (|upd_x) || (|upd_y);
    end else if (ev_drag || ev_drop) begin
      vel_x_nxt = upd_x;
      vel_y_nxt = upd_y;
      flick_nxt = !ev_drag;
    end else begin
      vel_x_nxt = '0;
      vel_y_nxt = '0;
      flick_nxt = 1'b0;
    end

    flick_cancel = ev_dec || ev_can || in_r.wheel_up || in_r.wheel_down;
    if (flick_cancel) begin
      vel_x_nxt = '0;
      vel_y_nxt = '0;
      flick_nxt = 1'b0;
    end
    drag_nxt = ev_drag;

    flags = '0;
    flags[pgr_pkg::EV_DECIDE]   = ev_dec;
    flags[pgr_pkg::EV_CANCEL]   = ev_can;
    flags[pgr_pkg::EV_WHEEL_UP] = in_r.wheel_up;
    flags[pgr_pkg::EV_WHEEL_DN] = in_r.wheel_down;
    flags[pgr_pkg::EV_MOVE]     = ev_move;
    flags[pgr_pkg::EV_DRAG]     = ev_drag;
    flags[pgr_pkg::EV_DROP]     = ev_drop;
    flags[pgr_pkg::EV_FLICK]    = flick_nxt;
    flags[pgr_pkg::EV_EXT]      = ev_ext;

    out_nxt.event_flags  = flags;
    out_nxt.any_event    = |flags;
    out_nxt.delta_x      = dx;
    out_nxt.delta_y      = dy;
    out_nxt.flick_vel_x  = vel_x_nxt;
    out_nxt.flick_vel_y  = vel_y_nxt;
    out_nxt.drag_start_x = start_x_nxt;
    out_nxt.drag_start_y = start_y_nxt;
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_r <= pgr_pkg::in_item_t'(in_tdata[$bits(pgr_pkg::in_item_t)-1:0]);
    end
    if (advance) begin
      out_r <= out_nxt;
    end
  end

  // control, configuration and tracked state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r     <= 1'b0;
      out_vld_r    <= 1'b0;
      trace_gain_r <= pgr_pkg::TRACE_GAIN_RST;
      fade_gain_r  <= pgr_pkg::FADE_GAIN_RST;
      last_prim_r  <= 1'b0;
      last_sec_r   <= 1'b0;
      last_mid_r   <= 1'b0;
      last_drag_r  <= 1'b0;
      last_flick_r <= 1'b0;
      click_en_r   <= 1'b0;
      last_x_r     <= '0;
      last_y_r     <= '0;
      vel_x_r      <= '0;
      vel_y_r      <= '0;
      start_x_r    <= '0;
      start_y_r    <= '0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          pgr_pkg::REG_TRACE_GAIN: trace_gain_r <= cfg_data;
          pgr_pkg::REG_FADE_GAIN:  fade_gain_r  <= cfg_data;
          default: ;
        endcase
      end
      if (advance) begin
        last_prim_r  <= in_r.button_primary;
        last_sec_r   <= in_r.button_secondary;
        last_mid_r   <= in_r.button_middle;
        last_drag_r  <= drag_nxt;
        last_flick_r <= flick_nxt;
        click_en_r   <= click_en_nxt;
        last_x_r     <= in_r.pos_x;
        last_y_r     <= in_r.pos_y;
        vel_x_r      <= vel_x_nxt;
        vel_y_r      <= vel_y_nxt;
        start_x_r    <= start_x_nxt;
        start_y_r    <= start_y_nxt;
      end
    end
  end

endmodule

// File: bench/tb_pointer_gesture_recognizer.sv
// testbench for pointer_gesture_recognizer: directed and random frame samples
// are checked against an in-bench gesture predictor, item by item
// depends on pgr_pkg and the pointer_gesture_recognizer rtl
module tb_pointer_gesture_recognizer;

  localparam longint VEL_MAX = (longint'(1) << (pgr_pkg::VEL_BITS - 1)) - 1;
  localparam longint VEL_MIN = -VEL_MAX - 1;
  localparam longint COORD_MAX = (longint'(1) << (pgr_pkg::COORD_BITS - 1)) - 1;
  localparam longint COORD_MIN = -COORD_MAX - 1;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [pgr_pkg::IN_TDATA_W-1:0]  in_tdata = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [pgr_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [pgr_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
  logic [pgr_pkg::GAIN_BITS-1:0]   cfg_data = '0;

  pointer_gesture_recognizer DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

  // gesture predictor state
  logic                          prev_primary = 1'b0;
  logic                          prev_secondary = 1'b0;
  logic                          prev_middle = 1'b0;
  logic                          prev_drag = 1'b0;
  logic                          prev_flick = 1'b0;
  logic                          click_armed = 1'b0;
  longint                        prev_x = 0;
  longint                        prev_y = 0;
  longint                        track_vx = 0;
  longint                        track_vy = 0;
  longint                        anchor_x = 0;
  longint                        anchor_y = 0;
  logic [pgr_pkg::GAIN_BITS-1:0] trace_gain_now = pgr_pkg::TRACE_GAIN_RST;
  logic [pgr_pkg::GAIN_BITS-1:0] fade_gain_now = pgr_pkg::FADE_GAIN_RST;

  pgr_pkg::in_item_t  pending_frames[$];
  pgr_pkg::out_item_t predicted_events[$];
  pgr_pkg::in_item_t  cur_frame = '0;
  bit                 in_busy = 1'b0;
  int                 send_wait = 0;
  bit                 send_burst = 1'b0;
  int                 recv_wait = 0;
  int                 hold_left = 0;
  bit                 recv_burst = 1'b0;
  int                 results_seen = 0;
  int                 mismatches = 0;
  int                 frames_queued = 0;
  int                 stim_x = 0;
  int                 stim_y = 0;
  pgr_pkg::out_item_t seen_result;
  pgr_pkg::out_item_t want_result;

  // v * gain / 256 toward zero, plus add, clamped to the velocity range
  function automatic longint scaled_vel(longint v, logic [pgr_pkg::GAIN_BITS-1:0] gain,
                                        longint add);
    longint sum;
    sum = (v * longint'(gain)) / 256 + add;
    if (sum > VEL_MAX) return VEL_MAX;
    if (sum < VEL_MIN) return VEL_MIN;
    return sum;
  endfunction

  function automatic pgr_pkg::out_item_t next_gesture(pgr_pkg::in_item_t s);
    pgr_pkg::out_item_t             r;
    longint                         px, py, dx, dy;
    logic                           ev_dec, ev_can, ev_ext, ev_move, ev_drag, ev_drop, ev_flick;
    logic [pgr_pkg::NUM_EVENTS-1:0] flags;
    px = longint'(s.pos_x);
    py = longint'(s.pos_y);
    dx = px - prev_x;
    dy = py - prev_y;
    ev_dec = !prev_primary && s.button_primary && !s.pos_clipped;
    ev_can = !prev_secondary && s.button_secondary && !s.pos_clipped;
    ev_ext = !prev_middle && s.button_middle && !s.pos_clipped;
    ev_move = (dx != 0) || (dy != 0);
    ev_flick = 1'b0;
    if (ev_dec) begin
      click_armed = 1'b1;
      anchor_x = px;
      anchor_y = py;
      track_vx = 0;
      track_vy = 0;
    end
    if (!s.button_primary) click_armed = 1'b0;
    ev_drag = click_armed && s.button_primary && prev_primary && (ev_move || prev_drag);
    ev_drop = !s.button_primary && prev_primary && prev_drag;
    if (!prev_flick) begin
      if (ev_drag || ev_drop) begin
        track_vx = scaled_vel(track_vx, trace_gain_now, dx);
        track_vy = scaled_vel(track_vy, trace_gain_now, dy);
        ev_flick = !ev_drag;
      end else begin
        track_vx = 0;
        track_vy = 0;
      end
    end else begin
      track_vx = scaled_vel(track_vx, fade_gain_now, 0);
      track_vy = scaled_vel(track_vy, fade_gain_now, 0);
      ev_flick = (track_vx != 0) || (track_vy != 0);
    end
    // a primary press, a secondary press (cancel) or a wheel step kills a running flick
    if (ev_dec || ev_can || s.wheel_up || s.wheel_down) begin
      ev_flick = 1'b0;
      track_vx = 0;
      track_vy = 0;
    end
    flags = '0;
    flags[pgr_pkg::EV_DECIDE]   = ev_dec;
    flags[pgr_pkg::EV_CANCEL]   = ev_can;
    flags[pgr_pkg::EV_WHEEL_UP] = s.wheel_up;
    flags[pgr_pkg::EV_WHEEL_DN] = s.wheel_down;
    flags[pgr_pkg::EV_MOVE]     = ev_move;
    flags[pgr_pkg::EV_DRAG]     = ev_drag;
    flags[pgr_pkg::EV_DROP]     = ev_drop;
    flags[pgr_pkg::EV_FLICK]    = ev_flick;
    flags[pgr_pkg::EV_EXT]      = ev_ext;
    prev_primary = s.button_primary;
    prev_secondary = s.button_secondary;
    prev_middle = s.button_middle;
    prev_drag = ev_drag;
    prev_flick = ev_flick;
    prev_x = px;
    prev_y = py;
    r.event_flags  = flags;
    r.any_event    = |flags;
    r.delta_x      = pgr_pkg::DELTA_BITS'(dx);
    r.delta_y      = pgr_pkg::DELTA_BITS'(dy);
    r.flick_vel_x  = pgr_pkg::VEL_BITS'(track_vx);
    r.flick_vel_y  = pgr_pkg::VEL_BITS'(track_vy);
    r.drag_start_x = pgr_pkg::COORD_BITS'(anchor_x);
    r.drag_start_y = pgr_pkg::COORD_BITS'(anchor_y);
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    $display("%0t: %s", $time, msg);
  endtask

  // sender side
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_busy = 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predicted_events.push_back(next_gesture(cur_frame));
        in_busy = 1'b0;
        if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
        send_wait = send_burst ? 0 : $urandom_range(0, 4);
      end
      if (!in_busy) begin
        if (send_wait > 0) begin
          send_wait--;
        end else if (pending_frames.size() != 0) begin
          cur_frame = pending_frames.pop_front();
          in_busy = 1'b1;
        end
      end
      in_tvalid <= in_busy;
      in_tdata <= pgr_pkg::IN_TDATA_W'(cur_frame);
    end
  end

  // receiver side
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        seen_result = pgr_pkg::out_item_t'(out_tdata[$bits(pgr_pkg::out_item_t)-1:0]);
        if (predicted_events.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
        end else begin
          want_result = predicted_events.pop_front();
          if (seen_result.event_flags !== want_result.event_flags)
            report_mismatch($sformatf("result %0d event_flags got %h expected %h", results_seen,
              seen_result.event_flags, want_result.event_flags));
          if (seen_result.any_event !== want_result.any_event)
            report_mismatch($sformatf("result %0d any_event got %b expected %b", results_seen,
              seen_result.any_event, want_result.any_event));
          if (seen_result.delta_x !== want_result.delta_x)
            report_mismatch($sformatf("result %0d delta_x got %0d expected %0d", results_seen,
              seen_result.delta_x, want_result.delta_x));
          if (seen_result.delta_y !== want_result.delta_y)
            report_mismatch($sformatf("result %0d delta_y got %0d expected %0d", results_seen,
              seen_result.delta_y, want_result.delta_y));
          if (seen_result.flick_vel_x !== want_result.flick_vel_x)
            report_mismatch($sformatf("result %0d flick_vel_x got %0d expected %0d", results_seen,
              seen_result.flick_vel_x, want_result.flick_vel_x));
          if (seen_result.flick_vel_y !== want_result.flick_vel_y)
            report_mismatch($sformatf("result %0d flick_vel_y got %0d expected %0d", results_seen,
              seen_result.flick_vel_y, want_result.flick_vel_y));
          if (seen_result.drag_start_x !== want_result.drag_start_x)
            report_mismatch($sformatf("result %0d drag_start_x got %0d expected %0d",
              results_seen, seen_result.drag_start_x, want_result.drag_start_x));
          if (seen_result.drag_start_y !== want_result.drag_start_y)
            report_mismatch($sformatf("result %0d drag_start_y got %0d expected %0d",
              results_seen, seen_result.drag_start_y, want_result.drag_start_y));
        end
        results_seen++;
        if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
        recv_wait = recv_burst ? 0 : $urandom_range(0, 4);
        // long back-pressure so the block fills and stalls its input
        if (results_seen % 250 == 100) hold_left = 150;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (recv_wait > 0) begin
        recv_wait--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic write_gain(logic [pgr_pkg::CFG_IDX_W-1:0] idx,
                            logic [pgr_pkg::GAIN_BITS-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == pgr_pkg::REG_TRACE_GAIN) trace_gain_now = val;
    else if (idx == pgr_pkg::REG_FADE_GAIN) fade_gain_now = val;
  endtask

  task automatic wait_drained();
    while (pending_frames.size() != 0 || in_busy || predicted_events.size() != 0)
      @(posedge clk);
  endtask

  task automatic push_frame(bit p, bit s, bit m, bit wu, bit wd, int x, int y, bit clip);
    pgr_pkg::in_item_t f;
    if (x > COORD_MAX) x = COORD_MAX;
    if (x < COORD_MIN) x = COORD_MIN;
    if (y > COORD_MAX) y = COORD_MAX;
    if (y < COORD_MIN) y = COORD_MIN;
    stim_x = x;
    stim_y = y;
    f.button_primary = p;
    f.button_secondary = s;
    f.button_middle = m;
    f.wheel_up = wu;
    f.wheel_down = wd;
    f.pos_x = pgr_pkg::COORD_BITS'(x);
    f.pos_y = pgr_pkg::COORD_BITS'(y);
    f.pos_clipped = clip;
    pending_frames.push_back(f);
    frames_queued++;
  endtask

  function automatic int move_step(bit big);
    if ($urandom_range(0, 5) == 0) return 0;
    if (big) return int'($urandom_range(0, 65535)) - 32768;
    return int'($urandom_range(0, 600)) - 300;
  endfunction

  // press, drag for a while, release, then coast with occasional interruptions
  task automatic queue_gesture();
    int unsigned n_drag, n_coast;
    bit          big;
    n_drag = $urandom_range(0, 8);
    n_coast = $urandom_range(0, 12);
    big = ($urandom_range(0, 7) == 0);
    push_frame(1, 0, 0, 0, 0, stim_x + move_step(0), stim_y + move_step(0),
               $urandom_range(0, 9) == 0);
    for (int i = 0; i < n_drag; i++)
      push_frame(1, $urandom_range(0, 7) == 0, $urandom_range(0, 7) == 0, 0, 0,
                 stim_x + move_step(big), stim_y + move_step(big), $urandom_range(0, 9) == 0);
    push_frame(0, 0, 0, 0, 0, stim_x + move_step(big), stim_y + move_step(big), 0);
    for (int i = 0; i < n_coast; i++)
      push_frame(0, $urandom_range(0, 14) == 0, $urandom_range(0, 14) == 0,
                 $urandom_range(0, 19) == 0, $urandom_range(0, 19) == 0,
                 stim_x + move_step(0), stim_y + move_step(0), $urandom_range(0, 9) == 0);
  endtask

  task automatic queue_random(int count);
    int target;
    target = frames_queued + count;
    while (frames_queued < target) begin
      if ($urandom_range(0, 9) < 8) begin
        queue_gesture();
      end else begin
        push_frame($urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1),
                   $urandom_range(0, 1), $urandom_range(0, 1),
                   int'($urandom_range(0, 65535)) - 32768,
                   int'($urandom_range(0, 65535)) - 32768, $urandom_range(0, 1));
      end
    end
  endtask

  logic [pgr_pkg::GAIN_BITS-1:0] trace_set[5] = '{8'd255, 8'd0, 8'd0, 8'd255, 8'd128};
  logic [pgr_pkg::GAIN_BITS-1:0] fade_set[5]  = '{8'd255, 8'd0, 8'd255, 8'd0, 8'd64};

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed frames at the reset gains
    push_frame(0, 0, 0, 0, 0, 0, 0, 0);
    push_frame(0, 0, 0, 0, 0, 32767, -32768, 0);
    push_frame(0, 0, 0, 0, 0, -32768, 32767, 0);
    push_frame(1, 0, 0, 0, 0, 100, 100, 0);
    push_frame(1, 0, 0, 0, 0, 1100, 600, 0);
    push_frame(1, 0, 0, 0, 0, 2100, 1100, 0);
    push_frame(1, 0, 0, 0, 0, 3100, 1600, 0);
    push_frame(1, 0, 0, 0, 0, 3100, 1600, 0);
    push_frame(0, 0, 0, 0, 0, 3200, 1650, 0);
    push_frame(0, 0, 0, 0, 0, 3200, 1650, 0);
    push_frame(0, 0, 0, 0, 0, 3200, 1650, 0);
    push_frame(0, 0, 0, 0, 0, 3200, 1650, 0);
    push_frame(0, 0, 0, 1, 0, 3200, 1650, 0);
    // press while off screen never arms a drag
    push_frame(1, 0, 0, 0, 0, 0, 0, 1);
    push_frame(1, 0, 0, 0, 0, 500, 500, 0);
    push_frame(0, 0, 0, 0, 0, 500, 500, 0);
    push_frame(1, 0, 0, 0, 0, 500, 500, 0);
    push_frame(1, 0, 0, 0, 0, -20000, -20000, 0);
    push_frame(0, 0, 0, 0, 0, -20000, -20000, 0);
    push_frame(0, 0, 0, 0, 0, -20000, -20000, 0);
    push_frame(0, 1, 0, 0, 0, -20000, -20000, 0);
    push_frame(0, 0, 1, 0, 0, -20001, -19999, 0);
    push_frame(0, 1, 1, 0, 1, -20001, -19999, 1);
    push_frame(1, 1, 1, 1, 1, 32767, 32767, 1);
    push_frame(0, 0, 0, 1, 1, -1, -1, 0);
    queue_random(160);
    wait_drained();

    for (int p = 0; p < 5; p++) begin
      if (p == 4) begin
        write_gain(pgr_pkg::REG_TRACE_GAIN, pgr_pkg::GAIN_BITS'($urandom_range(1, 254)));
        write_gain(pgr_pkg::REG_FADE_GAIN, pgr_pkg::GAIN_BITS'($urandom_range(1, 254)));
      end else begin
        write_gain(pgr_pkg::REG_TRACE_GAIN, trace_set[p]);
        write_gain(pgr_pkg::REG_FADE_GAIN, fade_set[p]);
      end
      queue_random(130);
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (mismatches == 0 && predicted_events.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/pgr_pkg.sv
rtl/pointer_gesture_recognizer.sv
bench/tb_pointer_gesture_recognizer.sv
